/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int ITEM_BITS     = 16;
    localparam int PRIORITY_BITS = 32;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    typedef logic [ITEM_BITS-1:0]            t_item;
    typedef logic signed [PRIORITY_BITS-1:0] t_prio;
    typedef logic [COUNT_BITS-1:0]           t_count;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_occ,
    input  spq_pkg::t_item     i_new_item,
    input  spq_pkg::t_prio     i_new_prio,
    input  logic               i_left_flag,
    input  spq_pkg::t_item     i_left_item,
    input  spq_pkg::t_prio     i_left_prio,
    input  spq_pkg::t_item     i_right_item,
    input  spq_pkg::t_prio     i_right_prio,
    output logic               o_flag,
    output spq_pkg::t_item     o_item,
    output spq_pkg::t_prio     o_prio
);
    import spq_pkg::*;

    t_item r_item, n_item;
    t_prio r_prio, n_prio;

    // The new entry belongs at or before this cell when the cell is empty or
    // holds a priority no smaller than the new one.
    assign o_flag = !i_occ || (r_prio >= i_new_prio);

    always_comb begin
        n_item = r_item;
        n_prio = r_prio;
        if (i_ctrl.ins) begin
            if (o_flag && !i_left_flag) begin
                n_item = i_new_item;
                n_prio = i_new_prio;
            end else if (o_flag) begin
                n_item = i_left_item;
                n_prio = i_left_prio;
            end
        end else if (i_ctrl.rem) begin
            n_item = i_right_item;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_prio <= n_prio;
    end

    assign o_item = r_item;
    assign o_prio = r_prio;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Sorted min-priority queue built as a row of cells, cell 0 holding the
// entry with the smallest priority.
// Input channel: an operation is transferred at a rising edge where start is
// high and busy is low. i_operation selects insert or remove; i_item_id and
// i_priority_req (signed Q16.16) carry the entry to insert.
// Result channel: exactly one result per operation, shown for one cycle with
// o_done high, in the cycle after the operation is transferred. The receiver
// cannot hold results off, and none is needed: every cell compares its own
// priority with the new one in parallel and shifts left or right in the same
// cycle, so a new operation may follow in every cycle. busy is therefore
// always low.
// A remove returns the front entry; on an empty queue it reports underflow.
// An insert into a full queue is dropped and reports overflow. Among equal
// priorities the newest entry is removed first.
// Reset clears the entry count, so the queue is empty afterwards; the cell
// contents are not cleared, as only cells below the count are ever read.
module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [15:0]        i_item_id,
    input  logic signed [31:0] i_priority_req,
    output logic               o_done,
    output logic [15:0]        o_out_item,
    output logic signed [31:0] o_out_priority,
    output logic [1:0]         o_status,
    output logic               o_now_empty,
    output logic [4:0]         o_entry_count
);
    import spq_pkg::*;

    t_count  r_count, n_count;
    logic    r_done;
    logic [15:0]        r_out_item, n_out_item;
    logic signed [31:0] r_out_prio, n_out_prio;
    t_status r_status, n_status;

    t_cell_ctrl w_ctrl;
    t_item      w_new_item;
    t_prio      w_new_prio;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;

    t_item w_item [CAPACITY];
    t_prio w_prio [CAPACITY];
    logic  w_flag [CAPACITY];

    // The block never stalls an operation, so busy is tied low.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_full  = (r_count == t_count'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_new_item = t_item'(i_item_id);
    assign w_new_prio = t_prio'(i_priority_req);

    always_comb begin
        w_ctrl     = '0;
        n_count    = r_count;
        n_out_item = '0;
        n_out_prio = '0;
        n_status   = ST_OK;
        if (w_accept) begin
            if (i_operation == OP_INSERT) begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_ctrl.ins = 1'b1;
                    n_count    = r_count + t_count'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_ctrl.rem = 1'b1;
                    n_count    = r_count - t_count'(1);
                    n_out_item = 16'(w_item[0]);
                    n_out_prio = 32'(w_prio[0]);
                end
            end
        end
    end

    // The row of cells. Each takes from its left neighbour on an insert behind
    // the insertion point and from its right neighbour on a remove.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_item w_left_item, w_right_item;
        t_prio w_left_prio, w_right_prio;
        logic  w_left_flag;

        if (g == 0) begin : g_first
            assign w_left_flag = 1'b0;
            assign w_left_item = w_new_item;
            assign w_left_prio = w_new_prio;
        end else begin : g_inner_l
            assign w_left_flag = w_flag[g-1];
            assign w_left_item = w_item[g-1];
            assign w_left_prio = w_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_item = '0;
            assign w_right_prio = '0;
        end else begin : g_inner_r
            assign w_right_item = w_item[g+1];
            assign w_right_prio = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (t_count'(g) < r_count),
            .i_new_item   (w_new_item),
            .i_new_prio   (w_new_prio),
            .i_left_flag  (w_left_flag),
            .i_left_item  (w_left_item),
            .i_left_prio  (w_left_prio),
            .i_right_item (w_right_item),
            .i_right_prio (w_right_prio),
            .o_flag       (w_flag[g]),
            .o_item       (w_item[g]),
            .o_prio       (w_prio[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_out_prio <= n_out_prio;
        r_status   <= n_status;
    end

    assign o_done         = r_done;
    assign o_out_item     = r_out_item;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_now_empty    = w_empty;
    assign o_entry_count  = 5'(r_count);

    // Every transferred operation gives a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("operation without result");

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count beyond capacity");

    // An overflow is only reported while the queue is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OVERFLOW) |-> w_full)
        else $error("overflow reported on a queue that is not full");

    // A successful remove drops exactly one entry.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_REMOVE && !w_empty)
            |=> (r_count == $past(r_count) - t_count'(1)))
        else $error("remove did not drop one entry");

endmodule
